// ----- rtl/core/fault_latch_with_hold_timers_macros.svh -----
// assertion helpers
`ifndef FAULT_LATCH_WITH_HOLD_TIMERS_MACROS_SVH
`define FAULT_LATCH_WITH_HOLD_TIMERS_MACROS_SVH

// same-cycle implication
`define FLTM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fault latch check failed");

// next-cycle implication
`define FLTM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fault latch check failed");

`endif

// ----- rtl/core/fltm_pkg.sv -----
`default_nettype none
package fltm_pkg;

  localparam int CRIT_FAULTS    = 16;
  localparam int NONCRIT_FAULTS = 16;
  localparam int NUM_TIMERS     = 32;
  localparam int NC_BASE        = 16;
  localparam int TMR_W          = $clog2(NUM_TIMERS);
  localparam int CNT_W          = $clog2(NUM_TIMERS + 1);
  localparam int HOLD_W         = 16;
  localparam int MAP_W          = 16;
  localparam int ID_W           = 6;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd4000;

  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } fltm_state_t;

  typedef struct packed {
    logic             arm;
    logic [TMR_W-1:0] arm_idx;
    logic             rd;
    logic [TMR_W-1:0] rd_idx;
    logic             dec;
    logic [TMR_W-1:0] dec_idx;
  } tmr_req_t;

  function automatic logic [MAP_W-1:0] frame16(input logic [MAP_W-1:0] v);
    logic [MAP_W-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[7-i]  = v[i];
      r[15-i] = v[8+i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fault_latch_with_hold_timers.sv -----
// Fault latch with one hold timer per fault. A request on the input stream is
// either a fault report (tuser = 1, fault id in tdata) or one time tick
// (tuser = 0). Critical ids 0-15 set a critical bit and the faulted state,
// ids 17-32 set a non-critical bit; each report restarts that fault's timer
// at hold_ticks and its result is ready in the cycle after acceptance. A tick
// walks all 32 timers through a single decrement-and-compare unit reading a
// 32-entry count memory one entry per cycle, then registers its result once the
// output slot is free; expired timers clear their bits and the block returns to
// ready when the last critical bit clears. Each request gives one result with
// both bitmaps, each byte bit-reversed. The user writes hold_ticks on the config
// channel only while no request is in progress; the block does not enforce it.
`default_nettype none
module fault_latch_with_hold_timers (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [7:0]                          in_tdata,  // src_id[5:0], zero pad
  input  wire  [0:0]                          in_tuser,  // func
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [31:0]                         out_tdata, // crit_frame, noncrit_frame
  output logic [2:0]                          out_tuser, // faulted, enter_fault, enter_ready
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [fltm_pkg::HOLD_W-1:0]         cfg_data
);
  import fltm_pkg::*;

  fltm_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [MAP_W-1:0]  crit_r, crit_nxt;
  logic [MAP_W-1:0]  noncrit_r, noncrit_nxt;
  logic              faulted_r, faulted_nxt;
  logic              clr_r, clr_nxt;
  logic [HOLD_W-1:0] hold_r;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r, out_data_nxt;
  logic [2:0]        out_user_r, out_user_nxt;

  tmr_req_t          req;
  logic              expired;
  logic              slot_free;
  logic              in_acc;
  logic [ID_W-1:0]   id;
  logic [ID_W-1:0]   nc_j;
  logic [TMR_W-1:0]  proc_idx;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign in_acc    = in_tvalid && in_tready;
  assign id        = in_tdata[ID_W-1:0];
  assign nc_j      = id - ID_W'(CRIT_FAULTS + 1);
  assign proc_idx  = TMR_W'(cnt_r - CNT_W'(1));
  assign cfg_ready = 1'b1;

  fltm_timers u_timers (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .hold_ticks (hold_r),
    .expired    (expired)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    crit_nxt      = crit_r;
    noncrit_nxt   = noncrit_r;
    faulted_nxt   = faulted_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    req           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == FUNC_REPORT) begin
            if (id < ID_W'(CRIT_FAULTS)) begin
              crit_nxt[id[3:0]] = 1'b1;
              faulted_nxt       = 1'b1;
              req.arm           = 1'b1;
              req.arm_idx       = TMR_W'(id);
            end else if (id > ID_W'(CRIT_FAULTS) &&
                         id <= ID_W'(CRIT_FAULTS + NONCRIT_FAULTS)) begin
              noncrit_nxt[nc_j[3:0]] = 1'b1;
              req.arm                = 1'b1;
              req.arm_idx            = TMR_W'(ID_W'(NC_BASE) + nc_j);
            end
            out_valid_nxt = 1'b1;
            out_data_nxt  = {frame16(noncrit_nxt), frame16(crit_nxt)};
            out_user_nxt  = {1'b0, (id < ID_W'(CRIT_FAULTS)), faulted_nxt};
          end else begin
            state_nxt = ST_SWEEP;
            cnt_nxt   = '0;
            clr_nxt   = 1'b0;
          end
        end
      end
      ST_SWEEP: begin
        // read entry cnt while settling entry cnt-1
        req.rd     = cnt_r < CNT_W'(NUM_TIMERS);
        req.rd_idx = cnt_r[TMR_W-1:0];
        if (cnt_r != '0) begin
          req.dec     = 1'b1;
          req.dec_idx = proc_idx;
          if (expired) begin
            if (proc_idx < TMR_W'(NC_BASE)) begin
              crit_nxt[proc_idx[3:0]] = 1'b0;
              clr_nxt                 = 1'b1;
            end else begin
              noncrit_nxt[proc_idx[3:0]] = 1'b0;
            end
          end
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_TIMERS)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          if (clr_r && crit_r == '0 && faulted_r) begin
            faulted_nxt = 1'b0;
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {frame16(noncrit_r), frame16(crit_r)};
          out_user_nxt  = {(clr_r && crit_r == '0 && faulted_r), 1'b0, faulted_nxt};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      crit_r      <= '0;
      noncrit_r   <= '0;
      faulted_r   <= 1'b0;
      clr_r       <= 1'b0;
      hold_r      <= HOLD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      crit_r      <= crit_nxt;
      noncrit_r   <= noncrit_nxt;
      faulted_r   <= faulted_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        hold_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`include "fault_latch_with_hold_timers_macros.svh"

  `FLTM_ASSERT_IMP(a_fault_implies_faulted, clk, rst_n, out_valid_r && out_user_r[1], out_user_r[0])
  `FLTM_ASSERT_IMP(a_ready_clears_all, clk, rst_n, out_valid_r && out_user_r[2], !out_user_r[0] && out_data_r[15:0] == '0)
  `FLTM_ASSERT_NXT(a_tick_starts_sweep, clk, rst_n, in_acc && in_tuser[0] == FUNC_TICK, state_r == ST_SWEEP && cnt_r == '0)
  `FLTM_ASSERT_IMP(a_sweep_bound, clk, rst_n, state_r == ST_SWEEP, cnt_r <= CNT_W'(NUM_TIMERS))

endmodule
`default_nettype wire

// ----- rtl/core/fltm_timers.sv -----
`default_nettype none
module fltm_timers (
  input  wire                          clk,
  input  wire                          rst_n,
  input  fltm_pkg::tmr_req_t           req,
  input  wire [fltm_pkg::HOLD_W-1:0]   hold_ticks,
  output logic                         expired
);
  import fltm_pkg::*;

  logic [HOLD_W-1:0]     cnt_mem [NUM_TIMERS];
  logic [HOLD_W-1:0]     rd_data_r;
  logic [NUM_TIMERS-1:0] running_r;
  logic [NUM_TIMERS-1:0] running_nxt;
  logic                  live;
  logic                  wr_dec;

  // shared decrement and compare unit
  assign live    = req.dec && running_r[req.dec_idx];
  assign wr_dec  = live && (rd_data_r > HOLD_W'(1));
  assign expired = live && !(rd_data_r > HOLD_W'(1));

  always_ff @(posedge clk) begin
    if (req.arm) begin
      cnt_mem[req.arm_idx] <= hold_ticks;
    end else if (wr_dec) begin
      cnt_mem[req.dec_idx] <= rd_data_r - HOLD_W'(1);
    end
    if (req.rd) begin
      rd_data_r <= cnt_mem[req.rd_idx];
    end
  end

  always_comb begin
    running_nxt = running_r;
    if (req.arm) begin
      running_nxt[req.arm_idx] = 1'b1;
    end
    if (expired) begin
      running_nxt[req.dec_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
    end else begin
      running_r <= running_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sim/fault_latch_with_hold_timers_test.sv -----
`timescale 1ns / 100ps

typedef struct packed {
  logic [fltm_pkg::MAP_W-1:0] crit_frame;
  logic [fltm_pkg::MAP_W-1:0] noncrit_frame;
  logic                       faulted;
  logic                       enter_fault;
  logic                       enter_ready;
} fault_status_t;

class fault_latch_tracker;
  logic [fltm_pkg::HOLD_W-1:0] hold;
  logic [fltm_pkg::MAP_W-1:0]  crit;
  logic [fltm_pkg::MAP_W-1:0]  noncrit;
  logic [fltm_pkg::HOLD_W-1:0] hold_left [fltm_pkg::NUM_TIMERS];
  bit                          armed [fltm_pkg::NUM_TIMERS];
  bit                          faulted;
  fault_status_t               status_due [$];
  int                          errors;

  function new();
    hold    = fltm_pkg::HOLD_RESET;
    crit    = '0;
    noncrit = '0;
    faulted = 1'b0;
    errors  = 0;
    for (int t = 0; t < fltm_pkg::NUM_TIMERS; t++) begin
      hold_left[t] = '0;
      armed[t]     = 1'b0;
    end
  endfunction

  function void set_hold(logic [fltm_pkg::HOLD_W-1:0] v);
    hold = v;
  endfunction

  function int pending_count();
    return status_due.size();
  endfunction

  function logic [fltm_pkg::MAP_W-1:0] byte_mirror(logic [fltm_pkg::MAP_W-1:0] v);
    logic [fltm_pkg::MAP_W-1:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i]     = v[7-i];
      r[8+i]   = v[15-i];
    end
    return r;
  endfunction

  function void start_timer(int t);
    hold_left[t] = hold;
    armed[t]     = 1'b1;
  endfunction

  function void record_request(logic func, logic [fltm_pkg::ID_W-1:0] id);
    fault_status_t s;
    bit crit_hit;
    int j;
    s = '0;
    crit_hit = 1'b0;
    if (func == fltm_pkg::FUNC_REPORT) begin
      if (id < fltm_pkg::CRIT_FAULTS) begin
        crit[id]      = 1'b1;
        faulted       = 1'b1;
        s.enter_fault = 1'b1;
        start_timer(int'(id));
      end else if (id > fltm_pkg::CRIT_FAULTS &&
                   id <= fltm_pkg::CRIT_FAULTS + fltm_pkg::NONCRIT_FAULTS) begin
        j = int'(id) - fltm_pkg::CRIT_FAULTS - 1;
        noncrit[j] = 1'b1;
        start_timer(fltm_pkg::NC_BASE + j);
      end
    end else begin
      for (int t = 0; t < fltm_pkg::NUM_TIMERS; t++) begin
        if (armed[t]) begin
          if (hold_left[t] > 1) begin
            hold_left[t] = hold_left[t] - 1'b1;
          end else begin
            hold_left[t] = '0;
            armed[t]     = 1'b0;
            if (t < fltm_pkg::NC_BASE) begin
              crit[t]  = 1'b0;
              crit_hit = 1'b1;
            end else begin
              noncrit[t-fltm_pkg::NC_BASE] = 1'b0;
            end
          end
        end
      end
      if (crit_hit && crit == '0 && faulted) begin
        faulted       = 1'b0;
        s.enter_ready = 1'b1;
      end
    end
    s.crit_frame    = byte_mirror(crit);
    s.noncrit_frame = byte_mirror(noncrit);
    s.faulted       = faulted;
    status_due.push_back(s);
  endfunction

  function void check_status(logic [31:0] data, logic [2:0] user);
    fault_status_t got;
    fault_status_t want;
    got.crit_frame    = data[15:0];
    got.noncrit_frame = data[31:16];
    got.faulted       = user[0];
    got.enter_fault   = user[1];
    got.enter_ready   = user[2];
    if (status_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: crit %h noncrit %h faulted %b enter_fault %b enter_ready %b",
                 got.crit_frame, got.noncrit_frame, got.faulted, got.enter_fault,
                 got.enter_ready);
      return;
    end
    want = status_due.pop_front();
    if (got.crit_frame !== want.crit_frame || got.noncrit_frame !== want.noncrit_frame ||
        got.faulted !== want.faulted || got.enter_fault !== want.enter_fault ||
        got.enter_ready !== want.enter_ready) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch: want crit %h noncrit %h faulted %b enter_fault %b enter_ready %b",
                 want.crit_frame, want.noncrit_frame, want.faulted, want.enter_fault,
                 want.enter_ready);
        $display("          got  crit %h noncrit %h faulted %b enter_fault %b enter_ready %b",
                 got.crit_frame, got.noncrit_frame, got.faulted, got.enter_fault,
                 got.enter_ready);
      end
    end
  endfunction
endclass

module fault_latch_with_hold_timers_test;
  import fltm_pkg::*;

  localparam int ID_LAST_NC = CRIT_FAULTS + NONCRIT_FAULTS;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;   // src_id[5:0], zero pad
  logic [0:0]        in_tuser = '0;   // func
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;       // crit_frame, noncrit_frame
  logic [2:0]        out_tuser;       // faulted, enter_fault, enter_ready
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [HOLD_W-1:0] cfg_data = '0;

  bit                 calm = 1'b0;
  fault_latch_tracker tracker;

  fault_latch_with_hold_timers dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 18));
  endfunction

  task automatic push_request(input logic func, input logic [ID_W-1:0] id);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {2'b00, id};
    do @(posedge clk); while (!in_tready);
    tracker.record_request(func, id);
  endtask

  task automatic write_hold(input logic [HOLD_W-1:0] v);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_hold(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int n);
    int done;
    int pick;
    int run_len;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 19);
      if (pick == 0 && tracker.hold <= 40) begin
        // tick run long enough to drain every timer armed with the current hold
        run_len = int'(tracker.hold) + 2;
        repeat (run_len) push_request(FUNC_TICK, ID_W'($urandom_range(0, 63)));
        done += run_len;
      end else begin
        if (pick < 10)
          push_request(FUNC_TICK, ID_W'($urandom_range(0, 63)));
        else if (pick < 14)
          push_request(FUNC_REPORT, ID_W'($urandom_range(0, CRIT_FAULTS - 1)));
        else if (pick < 18)
          push_request(FUNC_REPORT, ID_W'($urandom_range(CRIT_FAULTS + 1, ID_LAST_NC)));
        else if (pick == 18)
          push_request(FUNC_REPORT, ID_W'(CRIT_FAULTS));
        else
          push_request(FUNC_REPORT, ID_W'($urandom_range(ID_LAST_NC + 1, 63)));
        done++;
      end
    end
  endtask

  initial begin
    forever begin
      repeat ($urandom_range(200, 2000)) @(posedge clk);
      calm = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    #8_000_000;
    $display("fault_latch_with_hold_timers test failed");
    $finish;
  end

  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_status(out_tdata, out_tuser);
    end
  end

  initial begin
    tracker = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset hold time, every id class
    push_request(FUNC_REPORT, 6'd0);
    push_request(FUNC_REPORT, 6'd15);
    push_request(FUNC_REPORT, 6'd15);
    push_request(FUNC_REPORT, 6'd16);
    push_request(FUNC_REPORT, 6'd17);
    push_request(FUNC_REPORT, 6'd32);
    push_request(FUNC_REPORT, 6'd33);
    push_request(FUNC_REPORT, 6'd63);
    push_request(FUNC_TICK, 6'd63);

    // hold of one tick, return to ready
    write_hold(16'd1);
    push_request(FUNC_REPORT, 6'd0);
    push_request(FUNC_REPORT, 6'd15);
    push_request(FUNC_REPORT, 6'd5);
    push_request(FUNC_REPORT, 6'd20);
    push_request(FUNC_TICK, 6'd0);

    // zero hold, several expiries in one tick
    write_hold(16'd0);
    push_request(FUNC_REPORT, 6'd3);
    push_request(FUNC_REPORT, 6'd9);
    push_request(FUNC_REPORT, 6'd25);
    push_request(FUNC_TICK, 6'd42);

    // non-critical expiry leaves state alone
    write_hold(16'd2);
    push_request(FUNC_REPORT, 6'd7);
    push_request(FUNC_TICK, 6'd0);
    push_request(FUNC_REPORT, 6'd30);
    push_request(FUNC_TICK, 6'd0);
    push_request(FUNC_TICK, 6'd0);

    write_hold(16'd1);
    run_random(140);
    write_hold(16'd3);
    run_random(140);
    write_hold(16'hFFFF);
    run_random(140);
    write_hold(16'd0);
    run_random(140);
    write_hold(HOLD_W'($urandom_range(2, 8)));
    run_random(140);
    write_hold(HOLD_W'($urandom_range(9, 40)));
    run_random(140);
    write_hold(HOLD_W'($urandom_range(1, 4)));
    run_random(140);
    write_hold(HOLD_W'($urandom_range(41, 65534)));
    run_random(140);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending_count() == 0) begin
      $display("fault_latch_with_hold_timers test passed");
    end else begin
      $display("fault_latch_with_hold_timers test failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/fltm_pkg.sv
rtl/core/fltm_timers.sv
rtl/core/fault_latch_with_hold_timers.sv
sim/fault_latch_with_hold_timers_test.sv
